### design/assert_macros.svh
// Assertion macros used by the hole binning top level.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### design/ephb_pkg.sv
// Package for edge_point_hole_binning: payload structs, codes, constants, helpers.
// No dependencies.
package ephb_pkg;
   localparam int HOLES_PER_SIDE = 32;
   localparam int FRACTION_BITS = 4;
   localparam int CNT_W = $clog2(HOLES_PER_SIDE + 1);
   localparam int IDX_W = (HOLES_PER_SIDE > 1) ? $clog2(HOLES_PER_SIDE) : 1;
   localparam int ADDR_W = IDX_W + 1;
   localparam int DEPTH = 2 * HOLES_PER_SIDE;
   localparam int FIELD_W = 20;
   localparam int MARGIN_W = 12;
   localparam int CIRCLE_W = 3 * FIELD_W;
   // Box edges in whole pixels, signed; 19 bits covers -65536-4095 .. 131072+4095.
   localparam int EDGE_W = 19;
   localparam int BOX_W = 4 * EDGE_W;

   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_FINISH = 2'd1;
   localparam logic [1:0] FUNC_POINT = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_UNEQUAL = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   localparam logic KIND_FINISH = 1'b0;
   localparam logic KIND_POINT = 1'b1;

   localparam logic REG_CENTER_X = 1'b0;
   localparam logic REG_MARGIN = 1'b1;

   typedef struct packed {
      logic [1:0] func;
      logic [19:0] x_pos;
      logic [19:0] y_pos;
      logic [19:0] radius;
   } req_type;

   typedef struct packed {
      logic result_kind;
      logic [1:0] status;
      logic side;
      logic [4:0] hole_index;
      logic matched;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_RANK_RD,
      S_RANK_WAIT,
      S_RANK_CMP,
      S_BOX_WR,
      S_PT_RD,
      S_PT_WAIT,
      S_PT_CMP,
      S_OUT
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic take_req;      // latch the input word
      logic store_circle;  // write circle at side/count
      logic finish_eval;   // compute status
      logic set_ready;
      logic i_start;       // reset outer index for a side
      logic j_start;       // reset inner scan
      logic rd_j;          // read circle j
      logic rd_i;          // read circle i
      logic latch_i;       // capture circle i as pivot
      logic cmp_j;         // compare circle j with pivot
      logic wr_box;        // write box at rank
      logic next_i;
      logic next_side;
      logic pt_start;
      logic pt_cmp;
      logic out_finish;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic status_ok;
      logic j_last;
      logic i_last;
      logic side_empty;
      logic side_is_right;
      logic pt_hit;
      logic pt_last;
      logic pt_none;
   } sts_type;

   // floor((v + half) / 2^FRACTION_BITS) for a signed fixed value.
   function automatic logic signed [EDGE_W-1:0] round_px(input logic signed [FIELD_W+1:0] v);
      logic signed [FIELD_W+2:0] t;
      begin
         t = (FIELD_W+3)'(v) + (FIELD_W+3)'((1 << FRACTION_BITS) >> 1);
         round_px = EDGE_W'(t >>> FRACTION_BITS);
      end
   endfunction
endpackage

### design/ephb_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module ephb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input logic clock,
   input logic we,
   input logic [$clog2(DEPTH)-1:0] waddr,
   input logic [WIDTH-1:0] wdata,
   input logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

### design/ephb_ctrl.sv
// Controller state machine for hole binning.
// Depends on ephb_pkg.
module ephb_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input logic rsp_stall,
   input ephb_pkg::sts_type sts,
   output ephb_pkg::cmd_type cmd
);
   ephb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ephb_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ephb_pkg::S_IDLE: begin
            if (req_valid) state_in = ephb_pkg::S_LOAD;
         end
         ephb_pkg::S_LOAD: begin
            case (sts.func)
               ephb_pkg::FUNC_LOAD: state_in = ephb_pkg::S_IDLE;
               ephb_pkg::FUNC_FINISH: begin
                  if (!sts.status_ok) state_in = ephb_pkg::S_OUT;
                  else state_in = ephb_pkg::S_RANK_RD;
               end
               ephb_pkg::FUNC_POINT: state_in = ephb_pkg::S_PT_RD;
               default: state_in = ephb_pkg::S_IDLE;
            endcase
         end
         ephb_pkg::S_RANK_RD: begin
            if (sts.side_empty) begin
               state_in = sts.side_is_right ? ephb_pkg::S_OUT : ephb_pkg::S_RANK_RD;
            end else begin
               state_in = ephb_pkg::S_RANK_WAIT;
            end
         end
         ephb_pkg::S_RANK_WAIT: state_in = ephb_pkg::S_RANK_CMP;
         ephb_pkg::S_RANK_CMP: begin
            if (sts.j_last) state_in = ephb_pkg::S_BOX_WR;
            else state_in = ephb_pkg::S_RANK_WAIT;
         end
         ephb_pkg::S_BOX_WR: begin
            if (!sts.i_last) state_in = ephb_pkg::S_RANK_RD;
            else if (sts.side_is_right) state_in = ephb_pkg::S_OUT;
            else state_in = ephb_pkg::S_RANK_RD;
         end
         ephb_pkg::S_PT_RD: begin
            if (sts.pt_none) state_in = ephb_pkg::S_OUT;
            else state_in = ephb_pkg::S_PT_WAIT;
         end
         ephb_pkg::S_PT_WAIT: state_in = ephb_pkg::S_PT_CMP;
         ephb_pkg::S_PT_CMP: begin
            if (sts.pt_hit || sts.pt_last) state_in = ephb_pkg::S_OUT;
            else state_in = ephb_pkg::S_PT_WAIT;
         end
         ephb_pkg::S_OUT: begin
            if (!rsp_stall) state_in = ephb_pkg::S_IDLE;
         end
         default: state_in = ephb_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = (state_ff != ephb_pkg::S_IDLE);
      rsp_valid = (state_ff == ephb_pkg::S_OUT);
      case (state_ff)
         ephb_pkg::S_IDLE: cmd.take_req = req_valid;
         ephb_pkg::S_LOAD: begin
            case (sts.func)
               ephb_pkg::FUNC_LOAD: cmd.store_circle = 1'b1;
               ephb_pkg::FUNC_FINISH: begin
                  cmd.finish_eval = 1'b1;
                  cmd.i_start = 1'b1;
                  cmd.out_finish = 1'b1;
               end
               ephb_pkg::FUNC_POINT: cmd.pt_start = 1'b1;
               default: cmd = '0;
            endcase
         end
         ephb_pkg::S_RANK_RD: begin
            if (sts.side_empty) begin
               cmd.next_side = 1'b1;
               cmd.set_ready = sts.side_is_right;
            end else begin
               cmd.rd_i = 1'b1;
               cmd.j_start = 1'b1;
            end
         end
         ephb_pkg::S_RANK_WAIT: begin
            cmd.latch_i = 1'b1;
            cmd.rd_j = 1'b1;
         end
         ephb_pkg::S_RANK_CMP: cmd.cmp_j = 1'b1;
         ephb_pkg::S_BOX_WR: begin
            cmd.wr_box = 1'b1;
            cmd.next_i = 1'b1;
            cmd.next_side = sts.i_last;
            cmd.set_ready = sts.i_last && sts.side_is_right;
         end
         ephb_pkg::S_PT_RD, ephb_pkg::S_PT_WAIT, ephb_pkg::S_OUT: cmd = '0;
         ephb_pkg::S_PT_CMP: cmd.pt_cmp = 1'b1;
         default: cmd = '0;
      endcase
   end
endmodule

### design/ephb_dp.sv
// Datapath for hole binning: circle and box memories, counters, compares.
// Depends on ephb_pkg and ephb_ram.
module ephb_dp (
   input logic clock,
   input logic reset,
   input ephb_pkg::req_type req_word,
   input logic csr_write,
   input logic csr_index,
   input logic [19:0] csr_wdata,
   input ephb_pkg::cmd_type cmd,
   output ephb_pkg::sts_type sts,
   output ephb_pkg::rsp_type rsp_word
);
   localparam int AW = ephb_pkg::ADDR_W;
   localparam int IW = ephb_pkg::IDX_W;
   localparam int CW = ephb_pkg::CNT_W;
   localparam int EW = ephb_pkg::EDGE_W;

   logic [19:0] center_x_ff;
   logic [ephb_pkg::MARGIN_W-1:0] margin_ff;
   ephb_pkg::req_type word_ff;
   logic [CW-1:0] lcnt_ff, rcnt_ff;
   logic ready_ff, ovf_ff;
   logic side_ff;
   logic [CW-1:0] i_ff, j_ff, rank_ff;
   logic [59:0] piv_ff;
   ephb_pkg::rsp_type out_ff;
   logic [CW-1:0] k_ff;

   logic word_side;
   logic [CW-1:0] word_cnt;
   logic [CW-1:0] side_cnt;
   logic [CW-1:0] eff_cnt;
   logic circ_we;
   logic [AW-1:0] circ_waddr, circ_raddr, box_raddr;
   logic [59:0] circ_wdata, circ_rdata;
   logic [ephb_pkg::BOX_W-1:0] box_wdata, box_rdata;
   logic [1:0] fin_st;
   logic lc, rc;
   logic signed [21:0] cx, cy, cr;
   logic signed [EW-1:0] m;
   logic signed [EW+5:0] px, py, bl, bh, bt, bb;
   logic hit;

   assign word_side = (word_ff.x_pos < center_x_ff) ? 1'b0 : 1'b1;
   assign word_cnt = word_side ? rcnt_ff : lcnt_ff;
   assign side_cnt = side_ff ? rcnt_ff : lcnt_ff;
   assign lc = (lcnt_ff != '0);
   assign rc = (rcnt_ff != '0);

   always_comb begin
      if (ovf_ff) fin_st = ephb_pkg::ST_OVERFLOW;
      else if (!lc && !rc) fin_st = ephb_pkg::ST_EMPTY;
      else if (lc && rc && lcnt_ff != rcnt_ff) fin_st = ephb_pkg::ST_UNEQUAL;
      else fin_st = ephb_pkg::ST_OK;
   end

   // A load after a successful finish begins from empty counts.
   assign eff_cnt = ready_ff ? '0 : word_cnt;
   assign circ_we = cmd.store_circle && (eff_cnt < CW'(ephb_pkg::HOLES_PER_SIDE));
   assign circ_waddr = {word_side, eff_cnt[IW-1:0]};
   assign circ_wdata = {word_ff.x_pos, word_ff.y_pos, word_ff.radius};
   assign circ_raddr = cmd.rd_i ? {side_ff, i_ff[IW-1:0]} : {side_ff, j_ff[IW-1:0]};

   ephb_ram #(.WIDTH(60), .DEPTH(ephb_pkg::DEPTH)) u_circ (
      .clock(clock), .we(circ_we), .waddr(circ_waddr), .wdata(circ_wdata),
      .raddr(circ_raddr), .rdata(circ_rdata)
   );

   // Box from pivot circle.
   assign cx = 22'(piv_ff[59:40]);
   assign cy = 22'(piv_ff[39:20]);
   assign cr = 22'(piv_ff[19:0]);
   assign m = EW'(margin_ff);
   assign box_wdata = {ephb_pkg::round_px(cx - cr) - m, ephb_pkg::round_px(cx + cr) + m,
                       ephb_pkg::round_px(cy - cr) - m, ephb_pkg::round_px(cy + cr) + m};

   assign box_raddr = {word_side, k_ff[IW-1:0]};
   ephb_ram #(.WIDTH(ephb_pkg::BOX_W), .DEPTH(ephb_pkg::DEPTH)) u_box (
      .clock(clock), .we(cmd.wr_box), .waddr({side_ff, rank_ff[IW-1:0]}),
      .wdata(box_wdata), .raddr(box_raddr), .rdata(box_rdata)
   );

   assign px = (EW+6)'(word_ff.x_pos);
   assign py = (EW+6)'(word_ff.y_pos);
   assign bl = (EW+6)'($signed(box_rdata[4*EW-1:3*EW])) <<< ephb_pkg::FRACTION_BITS;
   assign bh = (EW+6)'($signed(box_rdata[3*EW-1:2*EW])) <<< ephb_pkg::FRACTION_BITS;
   assign bt = (EW+6)'($signed(box_rdata[2*EW-1:EW])) <<< ephb_pkg::FRACTION_BITS;
   assign bb = (EW+6)'($signed(box_rdata[EW-1:0])) <<< ephb_pkg::FRACTION_BITS;
   assign hit = (px >= bl) && (px < bh) && (py >= bt) && (py < bb);

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         margin_ff <= '0;
         lcnt_ff <= '0;
         rcnt_ff <= '0;
         ready_ff <= 1'b0;
         ovf_ff <= 1'b0;
      end else begin
         if (csr_write && csr_index == ephb_pkg::REG_CENTER_X) center_x_ff <= csr_wdata;
         if (csr_write && csr_index == ephb_pkg::REG_MARGIN)
            margin_ff <= csr_wdata[ephb_pkg::MARGIN_W-1:0];
         if (cmd.store_circle) begin
            // A load after success starts a new batch from cleared counts.
            if (ready_ff) ready_ff <= 1'b0;
            if (!circ_we) ovf_ff <= 1'b1;
            else if (ready_ff) ovf_ff <= 1'b0;
            if (circ_we && word_side) rcnt_ff <= eff_cnt + 1'b1;
            else if (ready_ff) rcnt_ff <= '0;
            if (circ_we && !word_side) lcnt_ff <= eff_cnt + 1'b1;
            else if (ready_ff) lcnt_ff <= '0;
         end
         if (cmd.finish_eval && fin_st != ephb_pkg::ST_OK) begin
            lcnt_ff <= '0;
            rcnt_ff <= '0;
            ovf_ff <= 1'b0;
            ready_ff <= 1'b0;
         end
         if (cmd.set_ready) ready_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) word_ff <= req_word;
      if (cmd.i_start) begin
         side_ff <= 1'b0;
         i_ff <= '0;
      end
      if (cmd.next_side) begin
         side_ff <= 1'b1;
         i_ff <= '0;
      end else if (cmd.next_i) begin
         i_ff <= i_ff + 1'b1;
      end
      if (cmd.j_start) begin
         j_ff <= '0;
         rank_ff <= '0;
      end
      if (cmd.latch_i && j_ff == '0) piv_ff <= circ_rdata;
      if (cmd.rd_j) j_ff <= j_ff + 1'b1;
      if (cmd.cmp_j && j_ff != '0) begin
         if (circ_rdata[39:20] < piv_ff[39:20] ||
             (circ_rdata[39:20] == piv_ff[39:20] && (j_ff - 1'b1) < i_ff))
            rank_ff <= rank_ff + 1'b1;
      end
      if (cmd.pt_start) k_ff <= '0;
      if (cmd.pt_cmp && !hit) k_ff <= k_ff + 1'b1;
      if (cmd.out_finish) begin
         out_ff <= {ephb_pkg::KIND_FINISH, fin_st, 1'b0, 5'd0, 1'b0};
      end
      if (cmd.pt_start) begin
         out_ff <= {ephb_pkg::KIND_POINT, 2'b00, word_side, 5'd0, 1'b0};
      end
      if (cmd.pt_cmp && hit) begin
         out_ff.matched <= 1'b1;
         out_ff.hole_index <= 5'(k_ff);
      end
   end

   // Rank scan: each wait reads circle j_ff and advances j, so the compare that
   // follows sees circle j_ff-1; the first wait also captures the pivot.
   always_comb begin
      sts = '0;
      sts.func = word_ff.func;
      sts.status_ok = (fin_st == ephb_pkg::ST_OK);
      sts.side_empty = (side_cnt == '0);
      sts.side_is_right = side_ff;
      sts.j_last = (j_ff == side_cnt);
      sts.i_last = (i_ff + 1'b1 == side_cnt);
      sts.pt_none = !ready_ff || (word_cnt == '0);
      sts.pt_hit = hit;
      sts.pt_last = (k_ff + 1'b1 == word_cnt);
   end

   assign rsp_word = out_ff;
endmodule

### design/edge_point_hole_binning.sv
// Top level of the hole binning block: controller plus datapath.
// Depends on ephb_pkg, ephb_ctrl, ephb_dp, ephb_ram and assert_macros.svh.
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid/req_stall  | ephb_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall  | ephb_pkg::rsp_type
//   csr     | in        | csr_write            | csr_index, csr_wdata
//
// One word is handled at a time. A point scans the boxes of its side in rank
// order through the single box memory read port and stops at the first hit.
// A finish ranks every circle against every circle of its side through the
// single circle memory read port. Reset is synchronous and clears counts and
// flags; the memories are not cleared. A stalled result holds the block.
`include "assert_macros.svh"
module edge_point_hole_binning (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input ephb_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output ephb_pkg::rsp_type rsp_data,
   input logic csr_write,
   input logic csr_index,
   input logic [19:0] csr_wdata
);
   ephb_pkg::cmd_type cmd;
   ephb_pkg::sts_type sts;

   // The controller sequences loads, the rank sort and the box scan.
   ephb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd)
   );

   // The datapath holds registers, counts and both memories.
   ephb_dp u_dp (
      .clock(clock), .reset(reset), .req_word(req_data), .csr_write(csr_write),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .cmd(cmd), .sts(sts),
      .rsp_word(rsp_data)
   );

   // A new word is never taken while a result waits.
   `ASSERT_IMPL(a_no_take_out, clock, reset, rsp_valid, req_stall, "input taken during output")
   // A stalled result stays valid.
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped")
   // A finish result never claims a match.
   `ASSERT_IMPL(a_fin_clean, clock, reset, rsp_valid && !rsp_data.result_kind,
                !rsp_data.matched, "finish with match")
endmodule

### tb/sv/edge_point_hole_binning_tb.sv
// Self-checking testbench for edge_point_hole_binning: loads circles, finishes
// batches and classifies edge points against a local model. Depends on ephb_pkg.
`timescale 1ns / 100ps
module edge_point_hole_binning_tb;
   localparam int LIMIT_CYCLES = 10000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HPS = ephb_pkg::HOLES_PER_SIDE;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ephb_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ephb_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic csr_index = 1'b0;
   logic [19:0] csr_wdata = '0;

   edge_point_hole_binning u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Model state: circles per side in arrival order, boxes per side in rank order.
   logic [19:0] circ_x [2][HPS];
   logic [19:0] circ_y [2][HPS];
   logic [19:0] circ_r [2][HPS];
   longint box_left [2][HPS];
   longint box_right [2][HPS];
   longint box_top [2][HPS];
   longint box_bottom [2][HPS];
   int side_count [2];
   bit boxes_ready;
   bit overflow_seen;
   logic [19:0] split_x;
   logic [11:0] margin;

   ephb_pkg::req_type pending_words[$];
   ephb_pkg::rsp_type expected_rsps[$];
   int error_count = 0;
   int sender_idle_pct = 17;
   int receiver_idle_pct = 64;
   longint cycle_count = 0;
   // The driver needs to know whether the word on the bus was held at the last rising edge.
   bit req_stall_seen = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic longint round_to_px(longint v);
      longint t;
      t = v + 8;
      if (t >= 0) return t / 16;
      return -((-t + 15) / 16);
   endfunction

   function automatic void clear_batch();
      side_count[0] = 0;
      side_count[1] = 0;
      overflow_seen = 1'b0;
      boxes_ready = 1'b0;
   endfunction

   function automatic void build_boxes(int s);
      int rank;
      longint x, y, r, mg;
      mg = longint'(margin);
      for (int i = 0; i < side_count[s]; i++) begin
         rank = 0;
         for (int j = 0; j < side_count[s]; j++) begin
            if (circ_y[s][j] < circ_y[s][i] || (circ_y[s][j] == circ_y[s][i] && j < i))
               rank++;
         end
         x = circ_x[s][i];
         y = circ_y[s][i];
         r = circ_r[s][i];
         box_left[s][rank] = round_to_px(x - r) - mg;
         box_right[s][rank] = round_to_px(x + r) + mg;
         box_top[s][rank] = round_to_px(y - r) - mg;
         box_bottom[s][rank] = round_to_px(y + r) + mg;
      end
   endfunction

   // Advances the model by one accepted word and queues the result it causes.
   function automatic void predict_binning(ephb_pkg::req_type w);
      int s, n;
      ephb_pkg::rsp_type res;
      res = '0;
      s = (w.x_pos < split_x) ? 0 : 1;
      case (w.func)
         ephb_pkg::FUNC_LOAD: begin
            if (boxes_ready) clear_batch();
            if (side_count[s] >= HPS) begin
               overflow_seen = 1'b1;
            end else begin
               circ_x[s][side_count[s]] = w.x_pos;
               circ_y[s][side_count[s]] = w.y_pos;
               circ_r[s][side_count[s]] = w.radius;
               side_count[s]++;
            end
         end
         ephb_pkg::FUNC_FINISH: begin
            res.result_kind = ephb_pkg::KIND_FINISH;
            if (overflow_seen) res.status = ephb_pkg::ST_OVERFLOW;
            else if (side_count[0] == 0 && side_count[1] == 0) res.status = ephb_pkg::ST_EMPTY;
            else if (side_count[0] != 0 && side_count[1] != 0 &&
                     side_count[0] != side_count[1]) res.status = ephb_pkg::ST_UNEQUAL;
            else res.status = ephb_pkg::ST_OK;
            if (res.status == ephb_pkg::ST_OK) begin
               build_boxes(0);
               build_boxes(1);
               boxes_ready = 1'b1;
            end else begin
               clear_batch();
            end
            expected_rsps = {expected_rsps, res};
         end
         ephb_pkg::FUNC_POINT: begin
            res.result_kind = ephb_pkg::KIND_POINT;
            res.side = s[0];
            n = boxes_ready ? side_count[s] : 0;
            for (int k = 0; k < n; k++) begin
               if (longint'(w.x_pos) >= box_left[s][k] * 16 &&
                   longint'(w.x_pos) < box_right[s][k] * 16 &&
                   longint'(w.y_pos) >= box_top[s][k] * 16 &&
                   longint'(w.y_pos) < box_bottom[s][k] * 16) begin
                  res.matched = 1'b1;
                  res.hole_index = k[4:0];
                  break;
               end
            end
            expected_rsps = {expected_rsps, res};
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   // Driver: presents the next pending word, holding it steady while stalled.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || !req_stall_seen) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_data <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // Monitor: model the accepted request, then check any accepted result.
   always @(posedge clock) begin
      ephb_pkg::rsp_type want;
      cycle_count <= cycle_count + 1;
      req_stall_seen <= req_valid && req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) predict_binning(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result kind", rsp_data.result_kind, -1);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.result_kind !== want.result_kind)
                  report_mismatch("result_kind", rsp_data.result_kind, want.result_kind);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.side !== want.side)
                  report_mismatch("side", rsp_data.side, want.side);
               if (rsp_data.hole_index !== want.hole_index)
                  report_mismatch("hole_index", rsp_data.hole_index, want.hole_index);
               if (rsp_data.matched !== want.matched)
                  report_mismatch("matched", rsp_data.matched, want.matched);
            end
         end
      end
      if (cycle_count > LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic ephb_pkg::req_type make_word(logic [1:0] f, logic [19:0] x,
                                                   logic [19:0] y, logic [19:0] r);
      ephb_pkg::req_type w;
      w.func = f;
      w.x_pos = x;
      w.y_pos = y;
      w.radius = r;
      return w;
   endfunction

   // A circle near the split line on the chosen side, with a modest radius.
   function automatic ephb_pkg::req_type random_circle(int right);
      logic [19:0] x;
      if (right) x = 20'(split_x + $urandom_range(4000));
      else x = (split_x > 0)
               ? 20'(split_x - 1 - $urandom_range(split_x > 4000 ? 3999 : split_x - 1))
               : 20'd0;
      return make_word(ephb_pkg::FUNC_LOAD, x, 20'($urandom_range(6000)),
                       20'($urandom_range(400)));
   endfunction

   // A point usually close to a loaded circle of this batch, so that hits happen.
   function automatic ephb_pkg::req_type random_point(ephb_pkg::req_type near[$]);
      ephb_pkg::req_type c;
      if (near.size() > 0 && $urandom_range(3) != 0) begin
         c = near[$urandom_range(near.size() - 1)];
         return make_word(ephb_pkg::FUNC_POINT, 20'(c.x_pos + $urandom_range(600) - 300),
                          20'(c.y_pos + $urandom_range(600) - 300), 20'($urandom()));
      end
      return make_word(ephb_pkg::FUNC_POINT, 20'($urandom()), 20'($urandom()),
                       20'($urandom()));
   endfunction

   task automatic write_register(logic idx, logic [19:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == ephb_pkg::REG_CENTER_X) split_x = value;
      else margin = value[11:0];
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Waits for the queue and the block to drain so a register can be changed safely.
   task automatic wait_idle();
      while (pending_words.size() > 0 || expected_rsps.size() > 0 || req_valid)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random batch: a load set (at times one-sided or with unequal counts), a finish and points.
   task automatic queue_batch();
      ephb_pkg::req_type batch[$];
      int n, mode;
      mode = $urandom_range(9);
      n = (mode == 0) ? HPS : $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
         if (mode != 1) batch = {batch, random_circle(1)};
         if (mode != 2) batch = {batch, random_circle(0)};
      end
      if (mode == 3) batch = {batch, random_circle($urandom_range(1))};
      if (mode == 4) for (int i = 0; i < 2; i++) batch = {batch, random_circle(1)};
      pending_words = {pending_words, batch};
      if (mode == 5)
         pending_words = {pending_words, make_word(ephb_pkg::FUNC_UNUSED, 20'($urandom()),
                                                   20'($urandom()), 20'($urandom()))};
      pending_words = {pending_words, make_word(ephb_pkg::FUNC_FINISH, 20'($urandom()),
                                                20'($urandom()), 20'($urandom()))};
      for (int i = $urandom_range(3, 12); i > 0; i--)
         pending_words = {pending_words, random_point(batch)};
      if ($urandom_range(7) == 0)
         pending_words = {pending_words, make_word(ephb_pkg::FUNC_FINISH, 20'($urandom()),
                                                   20'($urandom()), 20'($urandom()))};
   endtask

   initial begin
      int queued;
      clear_batch();
      split_x = '0;
      margin = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty finish, points before any success, field extremes, unused func.
      write_register(ephb_pkg::REG_CENTER_X, 20'd8000);
      write_register(ephb_pkg::REG_MARGIN, 20'd0);
      pending_words = {pending_words,
         make_word(ephb_pkg::FUNC_FINISH, 20'd0, 20'd0, 20'd0),
         make_word(ephb_pkg::FUNC_POINT, 20'd0, 20'd0, 20'd0),
         make_word(ephb_pkg::FUNC_POINT, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF),
         make_word(ephb_pkg::FUNC_UNUSED, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF)};
      // Ties in y, a radius beyond the center (negative edges) and extreme radius.
      pending_words = {pending_words,
         make_word(ephb_pkg::FUNC_LOAD, 20'd100, 20'd50, 20'd200),
         make_word(ephb_pkg::FUNC_LOAD, 20'd500, 20'd50, 20'd24),
         make_word(ephb_pkg::FUNC_LOAD, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF),
         make_word(ephb_pkg::FUNC_LOAD, 20'd8000, 20'd0, 20'd8),
         make_word(ephb_pkg::FUNC_FINISH, 20'd0, 20'd0, 20'd0),
         make_word(ephb_pkg::FUNC_POINT, 20'd0, 20'd0, 20'd0),
         make_word(ephb_pkg::FUNC_POINT, 20'd480, 20'd40, 20'd0),
         make_word(ephb_pkg::FUNC_POINT, 20'd8000, 20'd0, 20'd0),
         make_word(ephb_pkg::FUNC_POINT, 20'd7999, 20'd0, 20'd0),
         make_word(ephb_pkg::FUNC_FINISH, 20'd0, 20'd0, 20'd0)};
      // Unequal sides, then a one-sided batch that succeeds.
      pending_words = {pending_words,
         make_word(ephb_pkg::FUNC_LOAD, 20'd100, 20'd10, 20'd5),
         make_word(ephb_pkg::FUNC_LOAD, 20'd9000, 20'd10, 20'd5),
         make_word(ephb_pkg::FUNC_LOAD, 20'd9100, 20'd10, 20'd5),
         make_word(ephb_pkg::FUNC_FINISH, 20'd0, 20'd0, 20'd0),
         make_word(ephb_pkg::FUNC_LOAD, 20'd9000, 20'd100, 20'd32),
         make_word(ephb_pkg::FUNC_FINISH, 20'd0, 20'd0, 20'd0),
         make_word(ephb_pkg::FUNC_POINT, 20'd9000, 20'd100, 20'd0)};
      // Sender holds off until the block has answered everything.
      wait_idle();

      // Overflow on one side, with the widest margin and the largest split.
      write_register(ephb_pkg::REG_MARGIN, 20'hFFF);
      write_register(ephb_pkg::REG_CENTER_X, 20'hFFFFF);
      for (int i = 0; i <= HPS; i++)
         pending_words = {pending_words, make_word(ephb_pkg::FUNC_LOAD,
            20'($urandom_range(20'hFFFFE)), 20'($urandom()), 20'd1)};
      pending_words = {pending_words,
         make_word(ephb_pkg::FUNC_FINISH, 20'd0, 20'd0, 20'd0),
         make_word(ephb_pkg::FUNC_POINT, 20'd5, 20'd5, 20'd0)};
      wait_idle();

      // Random phases, each with its own register setting and idling mix.
      queued = 0;
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 64 : 0;
         receiver_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 17 : 0;
         write_register(ephb_pkg::REG_CENTER_X, 20'(2000 + $urandom_range(60000)));
         write_register(ephb_pkg::REG_MARGIN, (phase == 2) ? 20'd0 : 20'($urandom_range(3)));
         while (queued < 125 * (phase + 1)) begin
            queued -= pending_words.size();
            queue_batch();
            queued += pending_words.size();
            while (pending_words.size() > 0) @(posedge clock);
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
